// ----- rtl/lrfp_pkg.sv -----
// Package for the laser range frame parser: status codes, frame layout
// constants and the result struct passed from the frame core to the top level.
// No dependencies.
`default_nettype none

package lrfp_pkg;

    localparam int unsigned DIST_W = 20;

    localparam logic [3:0] CHECK_POS  = 4'd10;
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;
    localparam logic [7:0] CHAR_E     = 8'h45;
    localparam logic [7:0] CHAR_R     = 8'h52;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_OUT_OF_RANGE = 2'd1,
        ST_BAD_SUM      = 2'd2,
        ST_BAD_DIGIT    = 2'd3
    } status_t;

    typedef struct packed {
        logic               last;      // this item is the checksum byte
        logic [DIST_W-1:0]  distance;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/lrfp_frame_core.sv -----
// Frame state for the laser range frame parser: byte index, running sum,
// decimal accumulator and text/digit flags. Depends on lrfp_pkg.
`default_nettype none

module lrfp_frame_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              advance,
    output lrfp_pkg::result_t      result
);
    import lrfp_pkg::*;

    logic [3:0]        index_reg, index_next;
    logic [7:0]        sum_reg, sum_next;
    logic [DIST_W-1:0] acc_reg, acc_next;
    logic              err_match_reg, err_match_next;
    logic              fault_reg, fault_next;

    logic [7:0]        expected;
    logic [7:0]        digit_off;
    logic              is_digit;
    logic              is_check;

    always_comb
    begin
        expected  = 8'(~sum_reg + 8'd1);
        digit_off = 8'(rx_byte - ASCII_ZERO);
        is_digit  = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
        is_check  = (index_reg >= CHECK_POS);

        index_next     = 4'(index_reg + 4'd1);
        sum_next       = 8'(sum_reg + rx_byte);
        acc_next       = acc_reg;
        err_match_next = err_match_reg;
        fault_next     = fault_reg;

        result.last     = is_check;
        result.distance = '0;
        result.status   = ST_OK;

        if (is_check)
        begin
            if (rx_byte != expected)
                result.status = ST_BAD_SUM;
            else if (err_match_reg)
                result.status = ST_OUT_OF_RANGE;
            else if (fault_reg)
                result.status = ST_BAD_DIGIT;
            else
                result.distance = acc_reg;

            // frame done: back to the reset values
            index_next     = '0;
            sum_next       = '0;
            acc_next       = '0;
            err_match_next = 1'b1;
            fault_next     = 1'b0;
        end
        else
        begin
            case (index_reg) inside
                4'd3:
                begin
                    if (rx_byte != CHAR_E)
                        err_match_next = 1'b0;
                end
                4'd4, 4'd5:
                begin
                    if (rx_byte != CHAR_R)
                        err_match_next = 1'b0;
                end
                default:
                begin
                end
            endcase

            case (index_reg) inside
                4'd3, 4'd4, 4'd5, 4'd7, 4'd8, 4'd9:
                begin
                    // acc * 10 as two shifts, truncated to the field width
                    if (is_digit)
                        acc_next = {acc_reg[DIST_W-4:0], 3'b000}
                                 + {acc_reg[DIST_W-2:0], 1'b0}
                                 + {{(DIST_W-4){1'b0}}, digit_off[3:0]};
                    else
                        fault_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= '0;
            sum_reg       <= '0;
            acc_reg       <= '0;
            err_match_reg <= 1'b1;
            fault_reg     <= 1'b0;
        end
        else if (advance)
        begin
            index_reg     <= index_next;
            sum_reg       <= sum_next;
            acc_reg       <= acc_next;
            err_match_reg <= err_match_next;
            fault_reg     <= fault_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/laser_range_frame_parser.sv -----
// Top level of the laser range frame parser: input register, frame core and
// result register with valid/stall handshakes. Depends on lrfp_pkg and
// lrfp_frame_core.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_stall    rx_byte[7:0]
//   result   out        out_valid/out_stall  distance_milli[19:0], status[1:0]
//
// One byte is accepted per cycle while in_stall is low; a result comes
// from its checksum byte in the input register, via the result register.
// Frames of 11 bytes are counted from reset; reset clears the frame state.
// A stalled result holds its register; only a checksum byte waiting behind
// it holds the input register, so data bytes keep flowing.
`default_nettype none

module laser_range_frame_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [19:0]      distance_milli,
    output logic [1:0]       status
);
    import lrfp_pkg::*;

    logic              hold_valid_reg;
    logic [7:0]        hold_byte_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    status_t           status_reg;

    result_t           core_result;
    logic              out_free;
    logic              advance;
    logic              in_take;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = hold_valid_reg && (!core_result.last || out_free);
    assign in_stall = hold_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    lrfp_frame_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (hold_byte_reg),
        .advance (advance),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_take)
                hold_valid_reg <= 1'b1;
            else if (advance)
                hold_valid_reg <= 1'b0;

            if (advance && core_result.last)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            hold_byte_reg <= rx_byte;
        if (advance && core_result.last)
        begin
            dist_reg   <= core_result.distance;
            status_reg <= core_result.status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign distance_milli = dist_reg;
    assign status         = status_reg;

endmodule

`default_nettype wire

// ----- tb/tb_laser_range_frame_parser.sv -----
// Testbench for laser_range_frame_parser: a table of directed frames, then random frames
// checked against a shadow of the frame parser, under several sender/receiver idle mixes.
// Depends on lrfp_pkg and the laser_range_frame_parser RTL.
`timescale 1ns / 1ps

module tb_laser_range_frame_parser;
    import lrfp_pkg::*;

    typedef struct {
        logic [19:0] dist_milli;
        status_t     st;
    } reading_t;

    typedef enum int {
        FR_GOOD,
        FR_ERR,
        FR_BAD_DIGIT,
        FR_BAD_SUM,
        FR_NOISE
    } frame_kind_t;

    // body holds bytes 0..9 with byte 0 in the top bits; byte 10 is computed
    typedef struct {
        logic [79:0] body;
        bit          corrupt_sum;
        bit          typed;
        logic [19:0] dist_milli;
        status_t     st;
    } dir_row_t;

    localparam int N_DIR_ROWS       = 8;
    localparam int FRAMES_PER_PHASE = 12;
    localparam int FRAME_BYTES      = 11;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [19:0] distance_milli;
    logic [1:0]  status;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          err_count = 0;

    reading_t    due_readings[$];
    logic [7:0]  frame_buf [FRAME_BYTES];
    dir_row_t    dir_table [N_DIR_ROWS];

    // shadow of the parser's frame state
    logic [3:0]  trk_idx;
    logic [7:0]  trk_sum;
    logic [19:0] trk_acc;
    bit          trk_err_text;
    bit          trk_bad_char;

    laser_range_frame_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distance_milli (distance_milli),
        .status         (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
    begin
        $display("mismatch at %0t: %s got %0d, want %0d", $realtime, what, got, want);
        err_count++;
    end
    endtask

    task automatic clear_frame_track();
    begin
        trk_idx      = 4'd0;
        trk_sum      = 8'd0;
        trk_acc      = 20'd0;
        trk_err_text = 1'b1;
        trk_bad_char = 1'b0;
    end
    endtask

    // Advance the shadow by one byte; on the checksum byte return the reading.
    task automatic track_frame_byte(input logic [7:0] b, output bit done,
                                    output reading_t rd);
        logic [7:0] want_sum;
    begin
        done          = 1'b0;
        rd.dist_milli = 20'd0;
        rd.st         = ST_OK;
        if (trk_idx >= CHECK_POS)
        begin
            want_sum = ~trk_sum + 8'd1;
            done = 1'b1;
            if (b != want_sum)
                rd.st = ST_BAD_SUM;
            else if (trk_err_text)
                rd.st = ST_OUT_OF_RANGE;
            else if (trk_bad_char)
                rd.st = ST_BAD_DIGIT;
            else
                rd.dist_milli = trk_acc;
            clear_frame_track();
        end
        else
        begin
            trk_sum = trk_sum + b;
            if (trk_idx == 4'd3 && b != CHAR_E)
                trk_err_text = 1'b0;
            if ((trk_idx == 4'd4 || trk_idx == 4'd5) && b != CHAR_R)
                trk_err_text = 1'b0;
            if ((trk_idx >= 4'd3 && trk_idx <= 4'd5) || (trk_idx >= 4'd7 && trk_idx <= 4'd9))
            begin
                if (b >= ASCII_ZERO && b <= ASCII_NINE)
                    trk_acc = trk_acc * 20'd10 + {12'd0, b - ASCII_ZERO};
                else
                    trk_bad_char = 1'b1;
            end
            trk_idx = trk_idx + 4'd1;
        end
    end
    endtask

    // Present one item, hold it through stalls, and log the reading it completes.
    task automatic send_byte(input logic [7:0] b, input bit typed, input reading_t typed_rd);
        bit       done;
        reading_t rd;
    begin
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        track_frame_byte(b, done, rd);
        if (done)
        begin
            if (typed)
                due_readings.push_back(typed_rd);
            else
                due_readings.push_back(rd);
        end
    end
    endtask

    task automatic send_frame(input bit typed, input reading_t typed_rd);
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(frame_buf[i], typed && (i == FRAME_BYTES - 1), typed_rd);
    end
    endtask

    task automatic build_frame(input frame_kind_t kind);
        int         p;
        logic [7:0] s;
        logic [7:0] nd;
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
            frame_buf[i] = 8'($urandom_range(0, 255));
        if (kind != FR_NOISE)
        begin
            for (int i = 3; i <= 9; i++)
                if (i != 6)
                    frame_buf[i] = ASCII_ZERO + 8'($urandom_range(0, 9));
            if (kind == FR_ERR || (kind == FR_BAD_SUM && $urandom_range(2) == 0))
            begin
                frame_buf[3] = CHAR_E;
                frame_buf[4] = CHAR_R;
                frame_buf[5] = CHAR_R;
                // junk behind the out-of-range text must not matter
                if ($urandom_range(1) == 1)
                    frame_buf[7 + $urandom_range(0, 2)] = 8'($urandom_range(0, 255));
            end
            if (kind == FR_BAD_DIGIT)
            begin
                // near miss on the out-of-range text
                if ($urandom_range(3) == 0)
                begin
                    frame_buf[3] = CHAR_E;
                    frame_buf[4] = CHAR_R;
                end
                repeat ($urandom_range(1, 3))
                begin
                    p = $urandom_range(0, 5);
                    p = (p < 3) ? p + 3 : p + 4;
                    do
                        nd = 8'($urandom_range(0, 255));
                    while (nd >= ASCII_ZERO && nd <= ASCII_NINE);
                    frame_buf[p] = nd;
                end
            end
            s = 8'd0;
            for (int i = 0; i < FRAME_BYTES - 1; i++)
                s = s + frame_buf[i];
            frame_buf[10] = ~s + 8'd1;
            if (kind == FR_BAD_SUM)
                frame_buf[10] = frame_buf[10] + 8'($urandom_range(1, 255));
        end
    end
    endtask

    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (due_readings.size() == 0)
                report_mismatch("result with none pending, status", status, 0);
            else
            begin
                want = due_readings.pop_front();
                if (status !== want.st)
                    report_mismatch("status", status, want.st);
                if (distance_milli !== want.dist_milli)
                    report_mismatch("distance_milli", distance_milli, want.dist_milli);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        reading_t    tr;
        logic [7:0]  s;
        int          pick;
        frame_kind_t kind;

        clear_frame_track();

        dir_table[0] = '{{8'h00, 8'h00, 8'h00, "000", 8'h00, "000"}, 1'b0, 1'b1,
                         20'd0, ST_OK};
        dir_table[1] = '{{8'hFF, 8'hFF, 8'hFF, "999", 8'hFF, "999"}, 1'b0, 1'b1,
                         20'd999999, ST_OK};
        dir_table[2] = '{{8'h80, 8'h7F, 8'h01, "ERR", ".", "123"}, 1'b0, 1'b1,
                         20'd0, ST_OUT_OF_RANGE};
        // bad checksum wins over the out-of-range text
        dir_table[3] = '{{8'h55, 8'hAA, 8'h0F, "ERR", ".", "000"}, 1'b1, 1'b1,
                         20'd0, ST_BAD_SUM};
        // characters just below '0' and just above '9'
        dir_table[4] = '{{8'h12, 8'h34, 8'h56, "0/0", ".", ":99"}, 1'b0, 1'b1,
                         20'd0, ST_BAD_DIGIT};
        // out-of-range text wins over non-digits
        dir_table[5] = '{{8'h00, 8'hFF, 8'h00, "ERR", ".", "A!~"}, 1'b0, 1'b1,
                         20'd0, ST_OUT_OF_RANGE};
        dir_table[6] = '{{8'hF0, 8'h0F, 8'hC3, "ERX", ".", "123"}, 1'b0, 1'b1,
                         20'd0, ST_BAD_DIGIT};
        // byte 6 holds a digit, which must be left out of the distance
        dir_table[7] = '{{8'h3C, 8'h5A, 8'hA5, "123", "9", "456"}, 1'b0, 1'b0,
                         20'd0, ST_OK};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase

            if (ph == 0)
            begin
                for (int k = 0; k < N_DIR_ROWS; k++)
                begin
                    s = 8'd0;
                    for (int i = 0; i < FRAME_BYTES - 1; i++)
                    begin
                        frame_buf[i] = dir_table[k].body[79 - 8 * i -: 8];
                        s = s + frame_buf[i];
                    end
                    frame_buf[10] = ~s + 8'd1 + {7'd0, dir_table[k].corrupt_sum};
                    tr.dist_milli = dir_table[k].dist_milli;
                    tr.st         = dir_table[k].st;
                    send_frame(dir_table[k].typed, tr);
                end
            end

            for (int f = 0; f < FRAMES_PER_PHASE; f++)
            begin
                pick = $urandom_range(99);
                if (pick < 45)
                    kind = FR_GOOD;
                else if (pick < 55)
                    kind = FR_ERR;
                else if (pick < 70)
                    kind = FR_BAD_DIGIT;
                else if (pick < 85)
                    kind = FR_BAD_SUM;
                else
                    kind = FR_NOISE;
                build_frame(kind);
                tr.dist_milli = 20'd0;
                tr.st         = ST_OK;
                send_frame(1'b0, tr);
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        while (due_readings.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
